/* src/dcr_pkg.sv */
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types, codes and helpers for the drive command receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dcr_pkg;

    // Message / tick function codes
    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_STATE_REQ = 3'd1,
        FUNC_ENGAGE    = 3'd2,
        FUNC_SET_REF   = 3'd3
    } t_func;

    // Configuration register indexes
    localparam logic CFG_SPEED_STEP = 1'b0;
    localparam logic CFG_STEER_STEP = 1'b1;

    localparam int STEP_W = 15;
    localparam int VAL_W  = 16;
    localparam int SEQ_W  = 8;

    // Engage byte values
    localparam logic [7:0] ENGAGE_OFF = 8'd0;
    localparam logic [7:0] ENGAGE_ON  = 8'd1;

    // One accepted input word
    typedef struct packed {
        logic [2:0]              func;
        logic [SEQ_W-1:0]        seq_in;
        logic [7:0]              engage_value;
        logic signed [VAL_W-1:0] speed_target;
        logic signed [VAL_W-1:0] steer_target;
    } t_item;

    // One result word
    typedef struct packed {
        logic                    reply_valid;
        logic [SEQ_W-1:0]        reply_seq;
        logic                    reply_engaged;
        logic signed [VAL_W-1:0] reply_speed;
        logic signed [VAL_W-1:0] reply_steer;
        logic                    seq_error;
        logic                    restart_timeout;
        logic                    bad_engage;
    } t_result;

    // Sequence counter advance, zero is skipped
    function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] c);
        logic [SEQ_W-1:0] n;
        n = c + SEQ_W'(1);
        return (n == '0) ? SEQ_W'(1) : n;
    endfunction

endpackage

`default_nettype wire

/* src/dcr_core.sv */
// ----------------------------------------------------------------------------
// dcr_core
// Receiver state: sequence counters, engaged flag, references and the
// slewed current values. Updates on each accepted word and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire [14:0]            i_cfg_data,
    input  wire                   i_take,
    input  dcr_pkg::t_item        i_item,
    output dcr_pkg::t_result      o_result
);
    import dcr_pkg::*;

    logic [STEP_W-1:0]       r_speed_step;
    logic [STEP_W-1:0]       r_steer_step;
    logic [SEQ_W-1:0]        r_exp_state;
    logic [SEQ_W-1:0]        r_tx_count;
    logic [SEQ_W-1:0]        r_exp_engage;
    logic [SEQ_W-1:0]        r_exp_setref;
    logic                    r_engaged;
    logic signed [VAL_W-1:0] r_speed_ref;
    logic signed [VAL_W-1:0] r_steer_ref;
    logic signed [VAL_W-1:0] r_speed_now;
    logic signed [VAL_W-1:0] r_steer_now;

    logic signed [VAL_W-1:0] n_speed_now;
    logic signed [VAL_W-1:0] n_steer_now;

    // Move toward the reference by one step, stop at the reference
    function automatic logic signed [VAL_W-1:0] slew(
        input logic signed [VAL_W-1:0] now,
        input logic signed [VAL_W-1:0] ref_v,
        input logic [STEP_W-1:0]       step
    );
        logic signed [VAL_W+1:0] now_x;
        logic signed [VAL_W+1:0] ref_x;
        logic signed [VAL_W+1:0] step_x;
        logic signed [VAL_W+1:0] up;
        logic signed [VAL_W+1:0] dn;
        logic signed [VAL_W-1:0] res;
        now_x  = (VAL_W+2)'(now);
        ref_x  = (VAL_W+2)'(ref_v);
        step_x = $signed({3'b000, step});
        up     = now_x + step_x;
        dn     = now_x - step_x;
        if (ref_x > now_x) begin
            res = (up > ref_x) ? ref_v : up[VAL_W-1:0];
        end else if (ref_x < now_x) begin
            res = (dn < ref_x) ? ref_v : dn[VAL_W-1:0];
        end else begin
            res = now;
        end
        return res;
    endfunction

    assign n_speed_now = slew(r_speed_now, r_speed_ref, r_speed_step);
    assign n_steer_now = slew(r_steer_now, r_steer_ref, r_steer_step);

    // Result for the word at the input
    always_comb begin
        o_result = '0;
        case (i_item.func)
            FUNC_STATE_REQ: begin
                o_result.seq_error     = (i_item.seq_in != r_exp_state);
                o_result.reply_valid   = 1'b1;
                o_result.reply_seq     = r_tx_count;
                o_result.reply_engaged = r_engaged;
                o_result.reply_speed   = r_speed_now;
                o_result.reply_steer   = r_steer_now;
            end
            FUNC_ENGAGE: begin
                o_result.seq_error       = (i_item.seq_in != r_exp_engage);
                o_result.restart_timeout = (i_item.engage_value == ENGAGE_ON);
                o_result.bad_engage      = (i_item.engage_value != ENGAGE_ON) &&
                                           (i_item.engage_value != ENGAGE_OFF);
            end
            FUNC_SET_REF: begin
                o_result.seq_error       = (i_item.seq_in != r_exp_setref);
                o_result.restart_timeout = 1'b1;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // Step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_step <= STEP_W'(1);
            r_steer_step <= STEP_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SPEED_STEP) begin
                r_speed_step <= i_cfg_data;
            end
            if (i_cfg_index == CFG_STEER_STEP) begin
                r_steer_step <= i_cfg_data;
            end
        end
    end

    // State update per accepted word; on a mismatch the counter resyncs to
    // the received byte, so the next expected value is always next_seq(rx)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_state  <= SEQ_W'(1);
            r_tx_count   <= SEQ_W'(1);
            r_exp_engage <= SEQ_W'(1);
            r_exp_setref <= SEQ_W'(1);
            r_engaged    <= 1'b0;
            r_speed_ref  <= '0;
            r_steer_ref  <= '0;
            r_speed_now  <= '0;
            r_steer_now  <= '0;
        end else if (i_take) begin
            case (i_item.func)
                FUNC_TICK: begin
                    r_speed_now <= n_speed_now;
                    r_steer_now <= n_steer_now;
                end
                FUNC_STATE_REQ: begin
                    r_exp_state <= next_seq(i_item.seq_in);
                    r_tx_count  <= next_seq(r_tx_count);
                end
                FUNC_ENGAGE: begin
                    r_exp_engage <= next_seq(i_item.seq_in);
                    if (i_item.engage_value == ENGAGE_ON) begin
                        r_engaged <= 1'b1;
                    end else if (i_item.engage_value == ENGAGE_OFF) begin
                        r_engaged <= 1'b0;
                    end
                end
                FUNC_SET_REF: begin
                    r_exp_setref <= next_seq(i_item.seq_in);
                    if (r_engaged) begin
                        r_speed_ref <= i_item.speed_target;
                        r_steer_ref <= i_item.steer_target;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/drive_command_receiver_unit.sv */
// ----------------------------------------------------------------------------
// drive_command_receiver_unit
// Drive command receiver: sequence checks, engage control, reference store
// and per-tick slewing of speed and steering, one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carries one decoded message or
//   tick per word. Output channel: o_out_valid / i_out_stall carries exactly
//   one result word per input word, in order.
//   A word's result is registered into the output register, or into the skid
//   register while the output stalls. Throughput: one word per cycle when
//   not stalled; a single registered state update (18-bit add/sub and compares).
//   A two-entry output buffer (output register plus skid register) sits
//   behind the state logic, so a word is accepted while a finished result
//   waits. o_in_stall is registered: it rises only when both entries hold
//   results and falls once the output register is taken.
//   Reset (synchronous, active low) sets all sequence counters to 1, clears
//   the engaged flag, references and current values, sets both step
//   registers to 1 and empties the output buffer.
//   Step registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
//   the user must do so only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_receiver_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [14:0] i_cfg_data,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_func,
    input  wire  [7:0]  i_seq_in,
    input  wire  [7:0]  i_engage_value,
    input  wire  signed [15:0] i_speed_target,
    input  wire  signed [15:0] i_steer_target,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_reply_valid,
    output logic [7:0]  o_reply_seq,
    output logic        o_reply_engaged,
    output logic signed [15:0] o_reply_speed,
    output logic signed [15:0] o_reply_steer,
    output logic        o_seq_error,
    output logic        o_restart_timeout,
    output logic        o_bad_engage
);
    import dcr_pkg::*;

    t_item   item;
    t_result result;
    logic    take;
    logic    out_fire;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign item.func         = i_func;
    assign item.seq_in       = i_seq_in;
    assign item.engage_value = i_engage_value;
    assign item.speed_target = i_speed_target;
    assign item.steer_target = i_steer_target;

    assign take     = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;

    dcr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (item),
        .o_result    (result)
    );

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (take) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_reply_valid     = r_out.reply_valid;
    assign o_reply_seq       = r_out.reply_seq;
    assign o_reply_engaged   = r_out.reply_engaged;
    assign o_reply_speed     = r_out.reply_speed;
    assign o_reply_steer     = r_out.reply_steer;
    assign o_seq_error       = r_out.seq_error;
    assign o_restart_timeout = r_out.restart_timeout;
    assign o_bad_engage      = r_out.bad_engage;

endmodule

`default_nettype wire

/* src/dcr_checker.sv */
// ----------------------------------------------------------------------------
// dcr_checker
// Port-level checks on the drive command receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire        o_reply_valid,
    input wire [7:0]  o_reply_seq,
    input wire        o_reply_engaged,
    input wire [15:0] o_reply_speed,
    input wire [15:0] o_reply_steer,
    input wire        o_restart_timeout,
    input wire        o_bad_engage
);

    // stalled result word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // stalled reply counter does not move
    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_reply_seq))
        else $error("reply counter changed while stalled");

    // reply counter never reports zero
    a_seq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reply_valid |-> o_reply_seq != 8'd0)
        else $error("reply counter is zero");

    // no reply fields without a reply
    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reply_valid |->
            o_reply_seq == 8'd0 && !o_reply_engaged &&
            o_reply_speed == 16'd0 && o_reply_steer == 16'd0)
        else $error("reply fields set without reply");

    // flags of different message kinds never mix
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_bad_engage && o_restart_timeout) &&
            !(o_reply_valid && (o_bad_engage || o_restart_timeout)))
        else $error("conflicting result flags");

endmodule

bind drive_command_receiver_unit dcr_checker u_dcr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_reply_valid     (o_reply_valid),
    .o_reply_seq       (o_reply_seq),
    .o_reply_engaged   (o_reply_engaged),
    .o_reply_speed     (o_reply_speed),
    .o_reply_steer     (o_reply_steer),
    .o_restart_timeout (o_restart_timeout),
    .o_bad_engage      (o_bad_engage)
);

`default_nettype wire
